### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hdl/mbe_pkg.sv
package mbe_pkg;

	localparam int FRAC_BITS = 28;
	localparam int Q_W       = 32;
	localparam int STEP_W    = 31;
	localparam int COORD_W   = 10;
	localparam int LIMIT_W   = 16;
	localparam int SAT_W     = 43;

	// register indexes on the configuration port
	localparam logic [2:0] REG_REAL_START = 3'd0;
	localparam logic [2:0] REG_IMAG_START = 3'd1;
	localparam logic [2:0] REG_REAL_STEP  = 3'd2;
	localparam logic [2:0] REG_IMAG_STEP  = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

	localparam logic signed [Q_W-1:0] START_RST = -32'sd536870912;
	localparam logic [STEP_W-1:0]     STEP_RST  = 31'd1048576;
	localparam logic [LIMIT_W-1:0]    LIMIT_RST = 16'd256;

	localparam logic signed [SAT_W-1:0] Q_MAX = 43'sd2147483647;
	localparam logic signed [SAT_W-1:0] Q_MIN = -43'sd2147483648;

	// queue between mapping and iteration
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic signed [Q_W-1:0]  cr;
		logic signed [Q_W-1:0]  ci;
	} job_t;

	// clamp a wide signed value to the Q4.28 range
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX) begin
			r = Q_MAX[Q_W-1:0];
		end else if (v < Q_MIN) begin
			r = Q_MIN[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/mbe_front.sv
module mbe_front (
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mbe_pkg::COORD_W-1:0]         pixel_x,
	input  logic [mbe_pkg::COORD_W-1:0]         pixel_y,
	input  logic signed [mbe_pkg::Q_W-1:0]      real_start,
	input  logic signed [mbe_pkg::Q_W-1:0]      imag_start,
	input  logic [mbe_pkg::STEP_W-1:0]          real_step,
	input  logic [mbe_pkg::STEP_W-1:0]          imag_step,
	input  logic                                q_full,
	output logic                                q_push,
	output mbe_pkg::job_t                       q_data
);

	localparam int PROD_W = mbe_pkg::COORD_W + mbe_pkg::STEP_W;

	logic [PROD_W-1:0]                   prod_r;
	logic [PROD_W-1:0]                   prod_i;
	logic signed [mbe_pkg::SAT_W-1:0]    sum_r;
	logic signed [mbe_pkg::SAT_W-1:0]    sum_i;

	// c = start + coord * step, exact, then clamped
	assign prod_r = PROD_W'(pixel_x) * PROD_W'(real_step);
	assign prod_i = PROD_W'(pixel_y) * PROD_W'(imag_step);
	assign sum_r  = mbe_pkg::SAT_W'(real_start) + $signed(mbe_pkg::SAT_W'(prod_r));
	assign sum_i  = mbe_pkg::SAT_W'(imag_start) + $signed(mbe_pkg::SAT_W'(prod_i));

	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign q_data.x  = pixel_x;
	assign q_data.y  = pixel_y;
	assign q_data.cr = mbe_pkg::sat_q(sum_r);
	assign q_data.ci = mbe_pkg::sat_q(sum_i);

endmodule

### hdl/mbe_queue.sv
`include "assert_macros.svh"

module mbe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbe_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output mbe_pkg::job_t rdata,
	output logic          empty
);

	localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mbe_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue push while full")
	`ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue pop while empty")

endmodule

### hdl/mbe_core.sv
`include "assert_macros.svh"

module mbe_core #(
	parameter int CNT_W = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [CNT_W-1:0]                 limit,
	input  logic                             q_empty,
	input  mbe_pkg::job_t                    q_data,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mbe_pkg::COORD_W-1:0]      out_x,
	output logic [mbe_pkg::COORD_W-1:0]      out_y,
	output logic [mbe_pkg::LIMIT_W-1:0]      iterations,
	output logic                             inside_res
);

	localparam int Q_W  = mbe_pkg::Q_W;
	localparam int FB   = mbe_pkg::FRAC_BITS;
	localparam int SQ_W = 2 * Q_W - 1 - FB;     // nonnegative square, shifted
	localparam int XP_W = 2 * Q_W - (FB - 1);   // signed cross product, shifted

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	localparam logic [SQ_W:0] ESCAPE_SQ = (SQ_W + 1)'(4) << FB;

	logic [1:0]                       state_q;
	mbe_pkg::job_t                    job_q;
	logic signed [Q_W-1:0]            zr_q;
	logic signed [Q_W-1:0]            zi_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [SQ_W-1:0]                  zr2_q;
	logic [SQ_W-1:0]                  zi2_q;
	logic signed [XP_W-1:0]           xp_q;

	logic signed [2*Q_W-1:0]          sqr_w;
	logic signed [2*Q_W-1:0]          sqi_w;
	logic signed [2*Q_W-1:0]          xpr_w;
	logic [SQ_W:0]                    mag_w;
	logic                             stop_w;
	logic                             finish_w;
	logic signed [mbe_pkg::SAT_W-1:0] nr_w;
	logic signed [mbe_pkg::SAT_W-1:0] ni_w;

	// multiply cycle
	assign sqr_w = zr_q * zr_q;
	assign sqi_w = zi_q * zi_q;
	assign xpr_w = zr_q * zi_q;

	// add cycle: escape test, then update
	assign mag_w    = {1'b0, zr2_q} + {1'b0, zi2_q};
	assign stop_w   = (mag_w > ESCAPE_SQ) || (cnt_q >= limit);
	assign finish_w = (state_q == ST_ADD) && stop_w && (!out_valid || out_ready);
	assign nr_w     = $signed(mbe_pkg::SAT_W'(zr2_q)) - $signed(mbe_pkg::SAT_W'(zi2_q))
	                  + mbe_pkg::SAT_W'($signed(job_q.cr));
	assign ni_w     = mbe_pkg::SAT_W'(xp_q) + mbe_pkg::SAT_W'($signed(job_q.ci));

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (state_q == ST_MUL) begin
			zr2_q <= sqr_w[2*Q_W-2:FB];
			zi2_q <= sqi_w[2*Q_W-2:FB];
			xp_q  <= xpr_w[2*Q_W-1:FB-1];
		end
		if (finish_w) begin
			out_x      <= job_q.x;
			out_y      <= job_q.y;
			iterations <= mbe_pkg::LIMIT_W'(cnt_q);
			inside_res <= (cnt_q == limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			zr_q      <= '0;
			zi_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// a finishing pixel refills the register in the cycle it is taken
			if (finish_w) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						zr_q    <= '0;
						zi_q    <= '0;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!stop_w) begin
						zr_q    <= mbe_pkg::sat_q(nr_w);
						zi_q    <= mbe_pkg::sat_q(ni_w);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_MUL;
					end else if (finish_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, (state_q != ST_ADD) || (cnt_q <= limit),
		"iteration count passed the limit")
	`ASSERT_NEXT(a_finish_valid, finish_w, out_valid, "finished result not presented")
	`ASSERT_ALWAYS(a_inside_flag,
		!out_valid || (inside_res == (iterations == mbe_pkg::LIMIT_W'(limit))),
		"inside flag disagrees with iteration count")

endmodule

### hdl/mandelbrot_escape_time.sv
// Mandelbrot escape-time evaluator.
// Input channel (in_valid/in_ready): one transaction carries a pixel
// (pixel_x, pixel_y). The front maps it to c = start + coord * step in
// signed Q4.28, clamped, and parks it in a two-entry queue.
// Output channel (out_valid/out_ready): one transaction per pixel, in input
// order, with the pixel, the iteration count and the inside flag.
// Configuration: cfg_we/cfg_addr/cfg_wdata write real_start, imag_start,
// real_step, imag_step and iter_limit; write only while no pixel is in flight.
// Timing: each escape test in the iteration unit is a multiply state, then
// an add/compare/update state. A pixel is popped from the queue, then runs
// these tests until it escapes or reaches the limit.
// Throughput is set by the iteration unit; the queue lets the next pixels be
// taken while one is iterated.
// Stall: a finished result waits in the output register; the unit holds its
// last step until the register frees, while the queue takes pixels until full.
// Reset: registers return to start -2.0, step 1/256, limit 256; queue and
// output are emptied.
module mandelbrot_escape_time #(
	parameter int ITER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_addr,
	input  logic [mbe_pkg::Q_W-1:0]            cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mbe_pkg::COORD_W-1:0]        pixel_x,
	input  logic [mbe_pkg::COORD_W-1:0]        pixel_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mbe_pkg::COORD_W-1:0]        out_x,
	output logic [mbe_pkg::COORD_W-1:0]        out_y,
	output logic [mbe_pkg::LIMIT_W-1:0]        iterations,
	output logic                               inside_res
);

	// the limit is taken modulo 2^ITER_BITS; the register holds 16 bits
	localparam int CNT_W = (ITER_BITS < mbe_pkg::LIMIT_W) ? ITER_BITS : mbe_pkg::LIMIT_W;

	logic signed [mbe_pkg::Q_W-1:0]   real_start_q;
	logic signed [mbe_pkg::Q_W-1:0]   imag_start_q;
	logic [mbe_pkg::STEP_W-1:0]       real_step_q;
	logic [mbe_pkg::STEP_W-1:0]       imag_step_q;
	logic [mbe_pkg::LIMIT_W-1:0]      iter_limit_q;

	logic                             q_push;
	logic                             q_pop;
	logic                             q_full;
	logic                             q_empty;
	mbe_pkg::job_t                    q_wdata;
	mbe_pkg::job_t                    q_rdata;

	// configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_start_q <= mbe_pkg::START_RST;
			imag_start_q <= mbe_pkg::START_RST;
			real_step_q  <= mbe_pkg::STEP_RST;
			imag_step_q  <= mbe_pkg::STEP_RST;
			iter_limit_q <= mbe_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mbe_pkg::REG_REAL_START: real_start_q <= cfg_wdata;
				mbe_pkg::REG_IMAG_START: imag_start_q <= cfg_wdata;
				mbe_pkg::REG_REAL_STEP:  real_step_q  <= cfg_wdata[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_IMAG_STEP:  imag_step_q  <= cfg_wdata[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_ITER_LIMIT: iter_limit_q <= cfg_wdata[mbe_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: map the pixel to c and enqueue it
	mbe_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.real_start (real_start_q),
		.imag_start (imag_start_q),
		.real_step  (real_step_q),
		.imag_step  (imag_step_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// decouple mapping from iteration
	mbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back: iterate z = z^2 + c and hold the result for the receiver
	mbe_core #(
		.CNT_W (CNT_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.limit      (iter_limit_q[CNT_W-1:0]),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.iterations (iterations),
		.inside_res (inside_res)
	);

endmodule
